// ===== rtl/dhd_pkg.sv =====
// shared types, codes and constants of the double hash dictionary
package dhd_pkg;

   // string geometry
   localparam int STRING_LETTERS = 12;
   localparam int LETTER_BITS    = 3 * STRING_LETTERS;
   localparam int CODE_BITS      = 3;
   localparam int LIDX_BITS      = (STRING_LETTERS > 1) ? $clog2(STRING_LETTERS) : 1;

   // letter codes; anything above the last known letter adds nothing to the key
   localparam logic [CODE_BITS-1:0] CODE_PAD = 3'd0;
   localparam logic [CODE_BITS-1:0] CODE_A   = 3'd1;
   localparam logic [CODE_BITS-1:0] CODE_C   = 3'd2;
   localparam logic [CODE_BITS-1:0] CODE_G   = 3'd3;
   localparam logic [CODE_BITS-1:0] CODE_T   = 3'd4;

   // table and probe limit
   localparam int TABLE_SIZE_DEFAULT = 1021;
   localparam int PROBE_BITS         = 10;
   localparam logic [PROBE_BITS-1:0] MAX_PROBES_RESET = 10'd100;

   // modes
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_FIND   = 1'b1;

   // outcome codes
   localparam logic [1:0] OUT_STORED    = 2'd0;
   localparam logic [1:0] OUT_GAVE_UP   = 2'd1;
   localparam logic [1:0] OUT_FOUND     = 2'd2;
   localparam logic [1:0] OUT_NOT_FOUND = 2'd3;

   // request beat
   typedef struct packed {
      logic                   mode;
      logic [LETTER_BITS-1:0] key_chars;
   } req_type;

   // response beat
   typedef struct packed {
      logic [1:0]            outcome;
      logic [PROBE_BITS-1:0] probe_count;
   } rsp_type;

   // commands from controller to datapath
   typedef struct packed {
      logic       clear;
      logic       load;
      logic       fold;
      logic       seed;
      logic       read;
      logic       advance;
      logic       store;
      logic       set_outcome;
      logic [1:0] outcome;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic clear_last;
      logic fold_last;
      logic limit_zero;
      logic slot_valid;
      logic slot_match;
      logic limit_hit;
      logic mode_find;
   } status_type;

endpackage

// ===== rtl/double_hash_dictionary_unit.sv =====
// top level of the double hash dictionary: open addressing with double hashing
//
//  channel   ports                          beat taken when
//  request   start, busy, req_data          start high and busy low
//  response  rsp_valid, rsp_data            rsp_valid high, one cycle, no stall
//  csr       csr_we, csr_wdata (max_probes) csr_we high
//
// An item is accepted only in idle: the letters fold one per cycle, a seed step
// sets up the probe, each probe is a slot ram read and a check, then a response
// state returns to idle. A zero probe limit goes from the seed to the response.
// After reset a clearing pass writes every slot with busy high; csr writes are
// taken throughout. The response cannot be stalled.
module double_hash_dictionary_unit #(
   parameter int TABLE_SIZE = dhd_pkg::TABLE_SIZE_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  dhd_pkg::req_type               req_data,
   output logic                           rsp_valid,
   output dhd_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [dhd_pkg::PROBE_BITS-1:0] csr_wdata
);
   import dhd_pkg::*;

   cmd_type    cmd;
   status_type status;

   // controller
   dhd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // datapath
   dhd_datapath #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .status    (status),
      .rsp_data  (rsp_data)
   );

   // a response beat only closes an item in flight
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response beat while idle");

   // an accepted beat makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accept did not raise busy");

   // a stored or found result has probed at least one slot
   a_hit_probed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.outcome == OUT_STORED || rsp_data.outcome == OUT_FOUND))
      |-> (rsp_data.probe_count != '0))
      else $error("hit reported with no probe");

   // a slot is written only by the sweep or by an insert
   a_store_insert: assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> !status.mode_find && !status.slot_valid)
      else $error("store outside an insert into an empty slot");

endmodule

// ===== rtl/dhd_ram.sv =====
// generic single-port ram with registered read
module dhd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read of the same address
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/dhd_ctrl.sv =====
// controller state machine of the double hash dictionary
module dhd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  dhd_pkg::status_type status,
   output dhd_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_valid
);
   import dhd_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_FOLD  = 3'd2;
   localparam logic [2:0] ST_SEED  = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;
   localparam logic [2:0] ST_CHECK = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic [1:0] give_up_code;

   // outcome when the probe limit runs out
   assign give_up_code = status.mode_find ? OUT_NOT_FOUND : OUT_GAVE_UP;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            if (status.fold_last) begin
               state_in = ST_SEED;
            end
         end
         ST_SEED: begin
            cmd.seed = 1'b1;
            if (status.limit_zero) begin
               cmd.set_outcome = 1'b1;
               cmd.outcome     = give_up_code;
               state_in        = ST_DONE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (!status.slot_valid) begin
               cmd.set_outcome = 1'b1;
               cmd.store       = !status.mode_find;
               cmd.outcome     = status.mode_find ? OUT_NOT_FOUND : OUT_STORED;
               state_in        = ST_DONE;
            end else if (status.mode_find && status.slot_match) begin
               cmd.set_outcome = 1'b1;
               cmd.outcome     = OUT_FOUND;
               state_in        = ST_DONE;
            end else if (status.limit_hit) begin
               cmd.set_outcome = 1'b1;
               cmd.outcome     = give_up_code;
               state_in        = ST_DONE;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

endmodule

// ===== rtl/dhd_datapath.sv =====
// datapath: key folding, probe address, slot table and result registers
module dhd_datapath #(
   parameter int TABLE_SIZE = dhd_pkg::TABLE_SIZE_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  dhd_pkg::cmd_type                   cmd,
   input  dhd_pkg::req_type                   req_data,
   input  logic                               csr_we,
   input  logic [dhd_pkg::PROBE_BITS-1:0]     csr_wdata,
   output dhd_pkg::status_type                status,
   output dhd_pkg::rsp_type                   rsp_data
);
   import dhd_pkg::*;

   localparam int PTR_BITS  = $clog2(TABLE_SIZE);
   localparam int RES_BITS  = PTR_BITS + 3;
   localparam int ENTRY_BITS = LETTER_BITS + 1;

   // multiples of both moduli for the residue reduction
   localparam logic [RES_BITS-1:0] M1 = RES_BITS'(TABLE_SIZE);
   localparam logic [RES_BITS-1:0] M2 = RES_BITS'(2 * TABLE_SIZE);
   localparam logic [RES_BITS-1:0] M3 = RES_BITS'(3 * TABLE_SIZE);
   localparam logic [RES_BITS-1:0] M4 = RES_BITS'(4 * TABLE_SIZE);
   localparam logic [RES_BITS-1:0] N1 = RES_BITS'(TABLE_SIZE - 1);
   localparam logic [RES_BITS-1:0] N2 = RES_BITS'(2 * (TABLE_SIZE - 1));
   localparam logic [RES_BITS-1:0] N3 = RES_BITS'(3 * (TABLE_SIZE - 1));
   localparam logic [RES_BITS-1:0] N4 = RES_BITS'(4 * (TABLE_SIZE - 1));
   localparam logic [PTR_BITS:0]   SIZE_EXT = (PTR_BITS + 1)'(TABLE_SIZE);
   localparam logic [PTR_BITS-1:0] LAST_SLOT = PTR_BITS'(TABLE_SIZE - 1);

   // value below five times the modulus, brought under the modulus
   function automatic logic [PTR_BITS-1:0] reduce5(
      input logic [RES_BITS-1:0] v,
      input logic [RES_BITS-1:0] m1,
      input logic [RES_BITS-1:0] m2,
      input logic [RES_BITS-1:0] m3,
      input logic [RES_BITS-1:0] m4
   );
      logic [RES_BITS-1:0] r;
      begin
         priority if (v >= m4) r = v - m4;
         else if (v >= m3) r = v - m3;
         else if (v >= m2) r = v - m2;
         else if (v >= m1) r = v - m1;
         else r = v;
         reduce5 = r[PTR_BITS-1:0];
      end
   endfunction

   // cut the string at its first pad code
   function automatic logic [LETTER_BITS-1:0] cut_string(
      input logic [LETTER_BITS-1:0] raw
   );
      logic [LETTER_BITS-1:0] text;
      logic                   keep;
      begin
         text = '0;
         keep = 1'b1;
         for (int p = 0; p < STRING_LETTERS; p++) begin
            keep = keep && (raw[p*CODE_BITS +: CODE_BITS] != CODE_PAD);
            if (keep) begin
               text[p*CODE_BITS +: CODE_BITS] = raw[p*CODE_BITS +: CODE_BITS];
            end
         end
         cut_string = text;
      end
   endfunction

   logic                   mode_ff;
   logic [LETTER_BITS-1:0] text_ff;
   logic [LIDX_BITS-1:0]   lidx_ff;
   logic [PTR_BITS-1:0]    res_m_ff;
   logic [PTR_BITS-1:0]    res_n_ff;
   logic                   key_nz_ff;
   logic [PTR_BITS-1:0]    pos_ff;
   logic [PTR_BITS-1:0]    pos_in;
   logic [PTR_BITS-1:0]    step_ff;
   logic [PROBE_BITS-1:0]  probes_ff;
   logic [PROBE_BITS-1:0]  max_probes_ff;
   logic [1:0]             outcome_ff;

   logic [CODE_BITS-1:0]   code;
   logic                   code_known;
   logic [CODE_BITS-1:0]   key_add;
   logic [RES_BITS-1:0]    horner_m;
   logic [RES_BITS-1:0]    horner_n;
   logic [PTR_BITS:0]      pos_sum;
   logic                   ram_we;
   logic [ENTRY_BITS-1:0]  ram_wdata;
   logic [ENTRY_BITS-1:0]  ram_rdata;

   // horner step on both residues, last letter first
   assign code       = text_ff[lidx_ff * CODE_BITS +: CODE_BITS];
   assign code_known = (code != CODE_PAD) && (code <= CODE_T);
   assign key_add    = code_known ? code : CODE_PAD;
   assign horner_m   = RES_BITS'({res_m_ff, 2'b00}) + RES_BITS'(res_m_ff)
                       + RES_BITS'(key_add);
   assign horner_n   = RES_BITS'({res_n_ff, 2'b00}) + RES_BITS'(res_n_ff)
                       + RES_BITS'(key_add);

   // next probe slot wraps modulo table size
   assign pos_sum = {1'b0, pos_ff} + {1'b0, step_ff};

   always_comb begin
      pos_in = pos_ff;
      priority if (cmd.clear) begin
         pos_in = pos_ff + PTR_BITS'(1);
      end else if (cmd.seed) begin
         pos_in = key_nz_ff ? res_m_ff : PTR_BITS'(1);
      end else if (cmd.advance) begin
         pos_in = (pos_sum >= SIZE_EXT) ? PTR_BITS'(pos_sum - SIZE_EXT)
                                        : pos_sum[PTR_BITS-1:0];
      end else begin
         pos_in = pos_ff;
      end
   end

   // slot address doubles as the clearing sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // probe limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_probes_ff <= MAX_PROBES_RESET;
      end else if (csr_we) begin
         max_probes_ff <= csr_wdata;
      end
   end

   // item registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff   <= req_data.mode;
         text_ff   <= cut_string(req_data.key_chars);
         lidx_ff   <= LIDX_BITS'(STRING_LETTERS - 1);
         res_m_ff  <= '0;
         res_n_ff  <= '0;
         key_nz_ff <= 1'b0;
      end else if (cmd.fold) begin
         lidx_ff   <= lidx_ff - LIDX_BITS'(1);
         res_m_ff  <= reduce5(horner_m, M1, M2, M3, M4);
         res_n_ff  <= reduce5(horner_n, N1, N2, N3, N4);
         key_nz_ff <= key_nz_ff || (key_add != CODE_PAD);
      end
      if (cmd.seed) begin
         step_ff   <= (key_nz_ff ? res_n_ff : PTR_BITS'(1)) + PTR_BITS'(1);
         probes_ff <= '0;
      end else if (cmd.read) begin
         probes_ff <= probes_ff + PROBE_BITS'(1);
      end
      if (cmd.set_outcome) begin
         outcome_ff <= cmd.outcome;
      end
   end

   // slot table: valid bit over the stored letters
   assign ram_we    = cmd.clear || cmd.store;
   assign ram_wdata = cmd.clear ? '0 : {1'b1, text_ff};

   dhd_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (TABLE_SIZE)
   ) u_slots (
      .clock (clock),
      .we    (ram_we),
      .addr  (pos_ff),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // status to the controller
   assign status.clear_last = (pos_ff == LAST_SLOT);
   assign status.fold_last  = (lidx_ff == '0);
   assign status.limit_zero = (max_probes_ff == '0);
   assign status.slot_valid = ram_rdata[ENTRY_BITS-1];
   assign status.slot_match = (ram_rdata[LETTER_BITS-1:0] == text_ff);
   assign status.limit_hit  = (probes_ff == max_probes_ff);
   assign status.mode_find  = (mode_ff == MODE_FIND);

   assign rsp_data.outcome     = outcome_ff;
   assign rsp_data.probe_count = probes_ff;

endmodule
